>>> rtl/poi_pkg.sv
// shared types, constants and tables of the planar odometry integrator
package poi_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int POS_FRAC_BITS_DEF = 16;
	localparam int STEP_IDX_W = 5;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
	localparam logic signed [33:0] RAD_US_TO_BA = 34'sd44798134;
	localparam logic signed [63:0] VW_LIMIT = 64'sd4294967295;
	// one million = 64 * 15625, digit quotient = (cur * DIV_RECIP) >> 44
	localparam logic signed [33:0] DIV_RECIP = 34'sd1125899907;
	localparam logic [13:0] DIV_BASE = 14'd15625;
	localparam longint POS_MAX = 64'sd140737488355327;
	localparam longint POS_MIN = -64'sd140737488355328;

	// 16-bit digits of the position numerator after the divide by 64
	function automatic int div_digits(input int frac);
		return (58 + ((frac > 16) ? frac - 16 : 0) + 15) / 16;
	endfunction

	typedef struct packed {
		logic signed [31:0] yaw_rate;
		logic signed [31:0] vel_side;
		logic signed [31:0] vel_fwd;
		logic [47:0] stamp_us;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_z;
		logic [31:0] heading_angle;
		logic signed [47:0] pose_y;
		logic signed [47:0] pose_x;
		logic [47:0] out_stamp_us;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ROT, ST_SINCOS, ST_MFC, ST_MSS, ST_MFS, ST_MSC, ST_MXD, ST_MYD,
		ST_MWD, ST_MHI, ST_MLO, ST_DINIT, ST_DIV, ST_POS, ST_QROT, ST_PUB
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_CORDIC, OP_SINCOS, OP_MUL_FC, OP_MUL_SS, OP_MUL_FS,
		OP_MUL_SC, OP_MUL_XD, OP_MUL_YD, OP_MUL_WD, OP_MUL_HI, OP_MUL_LO,
		OP_HEAD, OP_DIV, OP_POS, OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic [STEP_IDX_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic seen_first;
	} sts_t;

	// arctangent of 2^-i as binary angle
	function automatic logic [31:0] atan_ba(input logic [STEP_IDX_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/poi_datapath.sv
// datapath: cordic, shared multiplier, reciprocal digit divider and pose accumulators
module poi_datapath #(
	parameter int POS_FRAC_BITS = poi_pkg::POS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input poi_pkg::cmd_t cmd,
	input poi_pkg::in_item_t in_item,
	output poi_pkg::sts_t sts,
	output poi_pkg::out_item_t out_item
);
	localparam int K = POS_FRAC_BITS - 16;
	localparam int KL = (K > 0) ? K : 0;
	localparam int KR = (K < 0) ? -K : 0;
	localparam int NW = 64 + KL;
	localparam int SW = NW + 2;
	localparam int DIG = poi_pkg::div_digits(POS_FRAC_BITS);
	localparam int NDW = 16 * DIG;
	localparam logic signed [SW-1:0] PMAX = SW'(poi_pkg::POS_MAX);
	localparam logic signed [SW-1:0] PMIN = SW'(poi_pkg::POS_MIN);

	logic [47:0] stamp_q, last_stamp_q;
	logic seen_first_q;
	logic signed [31:0] vf_q, vs_q, wr_q, dt_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic flip_q;
	logic signed [31:0] sin_q, cos_q;
	logic signed [67:0] prod_q;
	logic signed [63:0] sum_q;
	logic signed [32:0] vwx_q, vwy_q;
	logic [31:0] ulo_q, hsum_q, head_q;
	logic signed [47:0] acc_x_q, acc_y_q;
	logic [NDW-1:0] numx_q, numy_q;
	logic [13:0] remx_q, remy_q;
	logic negx_q, negy_q;
	poi_pkg::out_item_t out_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [48:0] dt_diff;
	logic signed [31:0] dt_sat;
	logic [31:0] init_ang;
	logic signed [32:0] init_z;
	logic init_flip;
	logic signed [33:0] nx, ny, dx, dy;
	logic signed [32:0] nz, at;
	logic signed [31:0] fin_x, fin_y;
	logic signed [NW:0] pnum;
	logic [NW-1:0] pmag;
	logic [29:0] curx, cury, qmul, rdx, rdy;
	logic [15:0] qdig;
	logic signed [SW-1:0] stepx, stepy, sumx, sumy;

	function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = v;
		if (v > poi_pkg::Q30_ONE) r = poi_pkg::Q30_ONE;
		else if (v < -poi_pkg::Q30_ONE) r = -poi_pkg::Q30_ONE;
		return r[31:0];
	endfunction

	function automatic logic signed [32:0] clamp_vw(input logic signed [63:0] v);
		logic signed [63:0] s;
		s = v >>> 30;
		if (s > poi_pkg::VW_LIMIT) s = poi_pkg::VW_LIMIT;
		else if (s < -poi_pkg::VW_LIMIT) s = -poi_pkg::VW_LIMIT;
		return s[32:0];
	endfunction

	function automatic logic signed [47:0] clamp_pos(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = v;
		if (v > PMAX) r = PMAX;
		else if (v < PMIN) r = PMIN;
		return r[47:0];
	endfunction

	// current partial dividend of each lane: remainder and next digit
	assign curx = {remx_q, numx_q[NDW-1 -: 16]};
	assign cury = {remy_q, numy_q[NDW-1 -: 16]};

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			poi_pkg::OP_MUL_FC: begin mul_a = 34'(vf_q); mul_b = 34'(cos_q); end
			poi_pkg::OP_MUL_SS: begin mul_a = 34'(vs_q); mul_b = 34'(sin_q); end
			poi_pkg::OP_MUL_FS: begin mul_a = 34'(vf_q); mul_b = 34'(sin_q); end
			poi_pkg::OP_MUL_SC: begin mul_a = 34'(vs_q); mul_b = 34'(cos_q); end
			poi_pkg::OP_MUL_XD: begin mul_a = 34'(vwx_q); mul_b = 34'(dt_q); end
			poi_pkg::OP_MUL_YD: begin mul_a = 34'(vwy_q); mul_b = 34'(dt_q); end
			poi_pkg::OP_MUL_WD: begin mul_a = 34'(wr_q); mul_b = 34'(dt_q); end
			poi_pkg::OP_MUL_HI: begin
				mul_a = $signed({2'b00, prod_q[63:32]});
				mul_b = poi_pkg::RAD_US_TO_BA;
			end
			poi_pkg::OP_MUL_LO: begin
				mul_a = $signed({2'b00, ulo_q});
				mul_b = poi_pkg::RAD_US_TO_BA;
			end
			poi_pkg::OP_DIV: begin
				if (cmd.step[0]) mul_a = $signed({4'b0000, cury});
				else mul_a = $signed({4'b0000, curx});
				mul_b = poi_pkg::DIV_RECIP;
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// saturated time step
	always_comb begin
		dt_diff = $signed({1'b0, in_item.stamp_us}) - $signed({1'b0, last_stamp_q});
		if (dt_diff > 49'sd2147483647) dt_sat = 32'sh7FFFFFFF;
		else if (dt_diff < -49'sd2147483648) dt_sat = 32'sh80000000;
		else dt_sat = dt_diff[31:0];
	end

	// cordic start: heading, or half the heading for the quaternion pass, folded into the right half plane
	always_comb begin
		init_ang = (cmd.op == poi_pkg::OP_POS) ? {1'b0, head_q[31:1]} : head_q;
		init_z = 33'($signed(init_ang));
		init_flip = 1'b0;
		if (init_z > 33'sd1073741824) begin
			init_z = init_z - 33'sd2147483648;
			init_flip = 1'b1;
		end else if (init_z < -33'sd1073741824) begin
			init_z = init_z + 33'sd2147483648;
			init_flip = 1'b1;
		end
	end

	// one cordic rotation, and the clamped sine and cosine of the current vector
	always_comb begin
		dx = cy_q >>> cmd.step;
		dy = cx_q >>> cmd.step;
		at = $signed({1'b0, poi_pkg::atan_ba(cmd.step)});
		if (cz_q >= 0) begin
			nx = cx_q - dx;
			ny = cy_q + dy;
			nz = cz_q - at;
		end else begin
			nx = cx_q + dx;
			ny = cy_q - dy;
			nz = cz_q + at;
		end
		fin_x = clamp_q30(flip_q ? -cx_q : cx_q);
		fin_y = clamp_q30(flip_q ? -cy_q : cy_q);
	end

	// position numerator scaled to the fraction width, as sign and magnitude
	always_comb begin
		pnum = (NW+1)'($signed(prod_q[64:0]));
		pnum = (pnum <<< KL) >>> KR;
		pmag = pnum[NW] ? NW'(-pnum) : pnum[NW-1:0];
	end

	// digit quotient from the registered reciprocal product, remainder of each lane, and the pose sums
	always_comb begin
		qdig = prod_q[59:44];
		qmul = 30'(qdig) * 30'(poi_pkg::DIV_BASE);
		rdx = curx - qmul;
		rdy = cury - qmul;
		stepx = negx_q ? -SW'(numx_q) : SW'(numx_q);
		stepy = negy_q ? -SW'(numy_q) : SW'(numy_q);
		sumx = SW'(acc_x_q) + stepx;
		sumy = SW'(acc_y_q) + stepy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q <= 1'b0;
			last_stamp_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			head_q <= '0;
		end else begin
			case (cmd.op)
				poi_pkg::OP_LOAD: begin
					seen_first_q <= 1'b1;
					if (!seen_first_q) last_stamp_q <= in_item.stamp_us;
				end
				poi_pkg::OP_HEAD: head_q <= head_q + hsum_q + prod_q[63:32];
				poi_pkg::OP_POS: begin
					acc_x_q <= clamp_pos(sumx);
					acc_y_q <= clamp_pos(sumy);
					last_stamp_q <= stamp_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			poi_pkg::OP_LOAD: begin
				stamp_q <= in_item.stamp_us;
				vf_q <= in_item.vel_fwd;
				vs_q <= in_item.vel_side;
				wr_q <= in_item.yaw_rate;
				dt_q <= dt_sat;
				cx_q <= poi_pkg::CORDIC_GAIN;
				cy_q <= '0;
				cz_q <= init_z;
				flip_q <= init_flip;
			end
			poi_pkg::OP_CORDIC: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
			end
			poi_pkg::OP_SINCOS: begin
				sin_q <= fin_y;
				cos_q <= fin_x;
			end
			poi_pkg::OP_MUL_SS: sum_q <= prod_q[63:0];
			poi_pkg::OP_MUL_FS: vwx_q <= clamp_vw(sum_q - prod_q[63:0]);
			poi_pkg::OP_MUL_SC: sum_q <= prod_q[63:0];
			poi_pkg::OP_MUL_XD: vwy_q <= clamp_vw(sum_q + prod_q[63:0]);
			poi_pkg::OP_MUL_YD: begin
				numx_q <= NDW'(pmag[NW-1:6]);
				negx_q <= pnum[NW];
				remx_q <= '0;
			end
			poi_pkg::OP_MUL_WD: begin
				numy_q <= NDW'(pmag[NW-1:6]);
				negy_q <= pnum[NW];
				remy_q <= '0;
			end
			poi_pkg::OP_MUL_HI: ulo_q <= prod_q[31:0];
			poi_pkg::OP_MUL_LO: hsum_q <= prod_q[31:0];
			poi_pkg::OP_DIV: begin
				// odd steps finish an x digit, even steps after the first a y digit
				if (cmd.step[0]) begin
					remx_q <= rdx[13:0];
					numx_q <= {numx_q[NDW-17:0], qdig};
				end else if (cmd.step != '0) begin
					remy_q <= rdy[13:0];
					numy_q <= {numy_q[NDW-17:0], qdig};
				end
			end
			poi_pkg::OP_POS: begin
				cx_q <= poi_pkg::CORDIC_GAIN;
				cy_q <= '0;
				cz_q <= init_z;
				flip_q <= init_flip;
			end
			poi_pkg::OP_PUBLISH: begin
				out_q.out_stamp_us <= stamp_q;
				out_q.pose_x <= acc_x_q;
				out_q.pose_y <= acc_y_q;
				out_q.heading_angle <= head_q;
				out_q.quat_z <= fin_y;
				out_q.quat_w <= fin_x;
			end
			default: ;
		endcase
	end

	assign sts.seen_first = seen_first_q;
	assign out_item = out_q;

endmodule

>>> rtl/poi_ctrl.sv
// controller: sequences one sample through the datapath and owns the handshakes
module poi_ctrl #(
	parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF,
	parameter int POS_FRAC_BITS = poi_pkg::POS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input poi_pkg::sts_t sts,
	output poi_pkg::cmd_t cmd
);
	localparam int DIV_STEPS = 2 * poi_pkg::div_digits(POS_FRAC_BITS) + 1;
	localparam int CNT_MAX = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
	localparam int CNT_W = ($clog2(CNT_MAX) > poi_pkg::STEP_IDX_W) ?
		$clog2(CNT_MAX) : poi_pkg::STEP_IDX_W;
	localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	poi_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= poi_pkg::ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd.op = poi_pkg::OP_NONE;
		cmd.step = cnt_q[poi_pkg::STEP_IDX_W-1:0];
		in_ready = 1'b0;
		case (state_q)
			poi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cnt_d = '0;
				if (in_valid) begin
					cmd.op = poi_pkg::OP_LOAD;
					if (sts.seen_first) state_d = poi_pkg::ST_ROT;
				end
			end
			poi_pkg::ST_ROT: begin
				cmd.op = poi_pkg::OP_CORDIC;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == ROT_LAST) begin
					cnt_d = '0;
					state_d = poi_pkg::ST_SINCOS;
				end
			end
			poi_pkg::ST_SINCOS: begin
				cmd.op = poi_pkg::OP_SINCOS;
				state_d = poi_pkg::ST_MFC;
			end
			poi_pkg::ST_MFC: begin cmd.op = poi_pkg::OP_MUL_FC; state_d = poi_pkg::ST_MSS; end
			poi_pkg::ST_MSS: begin cmd.op = poi_pkg::OP_MUL_SS; state_d = poi_pkg::ST_MFS; end
			poi_pkg::ST_MFS: begin cmd.op = poi_pkg::OP_MUL_FS; state_d = poi_pkg::ST_MSC; end
			poi_pkg::ST_MSC: begin cmd.op = poi_pkg::OP_MUL_SC; state_d = poi_pkg::ST_MXD; end
			poi_pkg::ST_MXD: begin cmd.op = poi_pkg::OP_MUL_XD; state_d = poi_pkg::ST_MYD; end
			poi_pkg::ST_MYD: begin cmd.op = poi_pkg::OP_MUL_YD; state_d = poi_pkg::ST_MWD; end
			poi_pkg::ST_MWD: begin cmd.op = poi_pkg::OP_MUL_WD; state_d = poi_pkg::ST_MHI; end
			poi_pkg::ST_MHI: begin cmd.op = poi_pkg::OP_MUL_HI; state_d = poi_pkg::ST_MLO; end
			poi_pkg::ST_MLO: begin cmd.op = poi_pkg::OP_MUL_LO; state_d = poi_pkg::ST_DINIT; end
			poi_pkg::ST_DINIT: begin cmd.op = poi_pkg::OP_HEAD; state_d = poi_pkg::ST_DIV; end
			poi_pkg::ST_DIV: begin
				cmd.op = poi_pkg::OP_DIV;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					state_d = poi_pkg::ST_POS;
				end
			end
			poi_pkg::ST_POS: begin
				cmd.op = poi_pkg::OP_POS;
				state_d = poi_pkg::ST_QROT;
			end
			poi_pkg::ST_QROT: begin
				cmd.op = poi_pkg::OP_CORDIC;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == ROT_LAST) begin
					cnt_d = '0;
					state_d = poi_pkg::ST_PUB;
				end
			end
			poi_pkg::ST_PUB: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = poi_pkg::OP_PUBLISH;
					out_valid_d = 1'b1;
					state_d = poi_pkg::ST_IDLE;
				end
			end
			default: state_d = poi_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == poi_pkg::OP_PUBLISH) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_rot_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == poi_pkg::ST_ROT || state_q == poi_pkg::ST_QROT) |-> (cnt_q <= ROT_LAST))
		else $error("cordic count out of range");
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == poi_pkg::ST_PUB))
		else $error("result raised outside publish");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == poi_pkg::ST_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divider count out of range");

endmodule

>>> rtl/planar_odometry_integrator.sv
// top level of the planar odometry integrator
//  channel  dir  bits  content
//  s_axis   in   144   request: stamp_us, vel_fwd, vel_side, yaw_rate
//  m_axis   out  240   pose: stamp, x, y, heading, quat_z, quat_w
// first request after reset only stores its stamp, no result
// later requests run a cordic pass, nine multiplies, the digit divide and a second
// cordic pass for the quaternion before the result is published
// a finished result waits in its output register while the next request is taken
// reset clears pose, heading and stored stamp
module planar_odometry_integrator #(
	parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF,
	parameter int POS_FRAC_BITS = poi_pkg::POS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [143:0] s_tdata, // stamp_us, vel_fwd, vel_side, yaw_rate
	output logic m_tvalid,
	input logic m_tready,
	output logic [239:0] m_tdata // out_stamp_us, pose_x, pose_y, heading_angle, quat_z, quat_w
);
	poi_pkg::cmd_t cmd;
	poi_pkg::sts_t sts;
	poi_pkg::in_item_t in_item;
	poi_pkg::out_item_t out_item;

	assign in_item = s_tdata;
	assign m_tdata = out_item;

	poi_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.sts(sts),
		.cmd(cmd)
	);

	poi_datapath #(
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_item(in_item),
		.sts(sts),
		.out_item(out_item)
	);

endmodule

>>> dv/testbench.sv
// self-checking testbench of the planar odometry integrator with a bit-exact pose predictor
`timescale 1ns / 100ps

module testbench;
	import poi_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam int FRAC = POS_FRAC_BITS_DEF;
	localparam int N_RANDOM = 1200;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [143:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [239:0] m_tdata;

	planar_odometry_integrator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predictor state
	logic [47:0] prev_stamp;
	logic have_first;
	longint pos_x, pos_y;
	logic [31:0] heading;

	out_item_t pose_queue[$];
	int mismatches;
	int poses_seen;
	int idle_cycles;
	bit timed_out;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void cordic_sincos(input logic [31:0] ang,
			output longint s, output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'($signed(ang));
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_ba(i[4:0]));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_ba(i[4:0]));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = clamp(y, -64'sd1073741824, 64'sd1073741824);
		c = clamp(x, -64'sd1073741824, 64'sd1073741824);
	endfunction

	function automatic longint travel(longint vw, longint dt);
		longint p, q, r, m;
		p = vw * dt;
		if (FRAC >= 16) begin
			m = longint'(1) << (FRAC - 16);
			q = p / 1000000;
			r = p % 1000000;
			return q * m + (r * m) / 1000000;
		end
		return (p >>> (16 - FRAC)) / 1000000;
	endfunction

	function automatic logic [31:0] turn(longint rate, longint dt);
		logic [63:0] u, hi, lo;
		u = rate * dt;
		hi = (u >> 32) * 64'd44798134;
		lo = ((u & 64'hFFFFFFFF) * 64'd44798134) >> 32;
		return hi[31:0] + lo[31:0];
	endfunction

	// returns 1 and the pose when the request produces one
	function automatic bit integrate(input in_item_t rq, output out_item_t ps);
		longint dt, s, c, vf, vs, wr, vwx, vwy, qz, qw;
		if (!have_first) begin
			prev_stamp = rq.stamp_us;
			have_first = 1;
			return 0;
		end
		dt = clamp(longint'({16'd0, rq.stamp_us}) - longint'({16'd0, prev_stamp}),
			-64'sd2147483648, 64'sd2147483647);
		vf = rq.vel_fwd;
		vs = rq.vel_side;
		wr = rq.yaw_rate;
		cordic_sincos(heading, s, c);
		vwx = clamp((vf * c - vs * s) >>> 30, -64'sd4294967295, 64'sd4294967295);
		vwy = clamp((vf * s + vs * c) >>> 30, -64'sd4294967295, 64'sd4294967295);
		pos_x = clamp(pos_x + travel(vwx, dt), POS_MIN, POS_MAX);
		pos_y = clamp(pos_y + travel(vwy, dt), POS_MIN, POS_MAX);
		heading = heading + turn(wr, dt);
		prev_stamp = rq.stamp_us;
		cordic_sincos({1'b0, heading[31:1]}, qz, qw);
		ps.out_stamp_us = rq.stamp_us;
		ps.pose_x = pos_x[47:0];
		ps.pose_y = pos_y[47:0];
		ps.heading_angle = heading;
		ps.quat_z = qz[31:0];
		ps.quat_w = qw[31:0];
		return 1;
	endfunction

	// receiver: stall pattern of its own
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[9:8] == 2'd3)
				m_tready <= 1'b1;
			else
				m_tready <= ((stall_phase % 7) != 3) && ($urandom_range(0, 3) != 0);
		end
	end

	// pose checker
	always @(posedge clk) begin
		out_item_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_item_t'(m_tdata);
			poses_seen++;
			if (pose_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pose: %h", got);
			end else begin
				want = pose_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("pose mismatch stamp %0d", want.out_stamp_us);
						$display("  x   exp %0d got %0d", want.pose_x, got.pose_x);
						$display("  y   exp %0d got %0d", want.pose_y, got.pose_y);
						$display("  hdg exp %0d got %0d", want.heading_angle,
							got.heading_angle);
						$display("  qz  exp %0d got %0d", want.quat_z, got.quat_z);
						$display("  qw  exp %0d got %0d", want.quat_w, got.quat_w);
					end
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or pose
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	// drive one request and wait for acceptance, with the predictor updated
	int burst_left;
	task automatic send_request(input in_item_t rq, input bit has_want,
			input out_item_t want);
		out_item_t ps;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rq;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (integrate(rq, ps)) begin
			if (has_want && ps !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("predictor disagrees with table row, stamp %0d", rq.stamp_us);
			end
			pose_queue.push_back(ps);
		end
	endtask

	typedef struct {
		in_item_t rq;
		bit has_want;
		out_item_t want;
	} row_t;

	function automatic in_item_t mk(logic [47:0] st, logic [31:0] vf, logic [31:0] vs,
			logic [31:0] wr);
		in_item_t r;
		r.stamp_us = st;
		r.vel_fwd = vf;
		r.vel_side = vs;
		r.yaw_rate = wr;
		return r;
	endfunction

	row_t rows[$];
	in_item_t rq;
	out_item_t none;
	logic [47:0] stamp;
	int kind;

	initial begin
		none = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		mismatches = 0;
		poses_seen = 0;
		idle_cycles = 0;
		timed_out = 0;
		burst_left = 0;
		prev_stamp = '0;
		have_first = 0;
		pos_x = 0;
		pos_y = 0;
		heading = '0;

		// first request only stores its stamp
		rows.push_back('{mk(48'd1000, 32'sd65536, 0, 0), 0, none});
		// zero speed, zero dt: pose stays at origin, heading zero
		rows.push_back('{mk(48'd1000, 0, 0, 0), 0, none});
		rows.push_back('{mk(48'd2000, 0, 0, 0), 0, none});
		rows.push_back('{mk(48'd1002000, 32'sd65536, 0, 0), 0, none});
		rows.push_back('{mk(48'd3002000, 32'h7FFFFFFF, 32'h80000000, 32'h00010000), 0, none});
		// backwards in time
		rows.push_back('{mk(48'd1000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000), 0, none});
		// saturated dt in both directions
		rows.push_back('{mk(48'hFFFFFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, none});
		rows.push_back('{mk(48'hFFFFFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, none});
		rows.push_back('{mk(48'h800000000000, 32'h80000000, 32'h80000000, 32'h80000000), 0, none});
		rows.push_back('{mk(48'h0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF), 0, none});
		rows.push_back('{mk(48'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0, none});
		// large position steps at full speed with saturated dt
		for (int i = 0; i < 6; i++)
			rows.push_back('{mk(48'h1000000000 * (i + 1), 32'h7FFFFFFF, 32'h7FFFFFFF,
				32'h00123456), 0, none});
		// sweep the heading around the turn
		for (int i = 0; i < 6; i++)
			rows.push_back('{mk(48'h7000000000 + 48'd400000 * i, 32'h00010000, 32'hFFFF0000,
				32'h00070000), 0, none});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_request(rows[i].rq, rows[i].has_want, rows[i].want);

		// random part: mostly steady time steps, some jumps and noise
		stamp = 48'($urandom);
		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 19);
			if (kind < 14)
				stamp = stamp + $urandom_range(0, 20000);
			else if (kind < 16)
				stamp = stamp - $urandom_range(0, 20000);
			else
				stamp = 48'({$urandom, $urandom});
			rq.stamp_us = stamp;
			if (kind < 12) begin
				rq.vel_fwd = $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
				rq.vel_side = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
				rq.yaw_rate = $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
			end else begin
				rq.vel_fwd = $urandom;
				rq.vel_side = $urandom;
				rq.yaw_rate = $urandom;
			end
			send_request(rq, 0, none);
		end
		s_tvalid <= 1'b0;

		while (pose_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d requests (%0d table rows), checked %0d poses, %0d mismatches",
			rows.size() + N_RANDOM, rows.size(), poses_seen, mismatches);
		$display("covered saturated dt, backward time, position saturation, heading wrap");
		if (mismatches == 0 && pose_queue.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
rtl/poi_pkg.sv
rtl/poi_datapath.sv
rtl/poi_ctrl.sv
rtl/planar_odometry_integrator.sv
dv/testbench.sv
